/* rtl/core/ohtab_pkg.sv */
// Package for the open addressing hash table core.
// Holds request/response/slot types, codes and controller interface structs.
// No dependencies.
`default_nettype none
package ohtab_pkg;

  localparam logic [1:0] T_BOOL = 2'd0;
  localparam logic [1:0] T_NIL  = 2'd1;
  localparam logic [1:0] T_NUM  = 2'd2;
  localparam logic [1:0] T_OBJ  = 2'd3;

  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_GET    = 2'd1;
  localparam logic [1:0] KIND_DEL    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NIL  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  key_type;
    logic [63:0] key_bits;
    logic        key_is_string;
    logic [31:0] key_string_hash;
    logic [1:0]  value_type;
    logic [63:0] value_bits;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  found_type;
    logic [63:0] found_bits;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  key_type;
    logic [63:0] key_bits;
    logic [1:0]  value_type;
    logic [63:0] value_bits;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } state_e;

  typedef enum logic [1:0] {
    WR_SET,
    WR_TOMB,
    WR_CLR
  } wr_sel_e;

  typedef struct packed {
    logic       clr;
    logic       ld;
    logic       mod;
    logic       rd;
    logic       step;
    logic       wr;
    wr_sel_e    wr_sel;
    logic       wr_at_idx;
    logic       used_inc;
    logic       res;
    logic [1:0] res_sts;
    logic       res_found;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       mod_last;
    logic       in_nil;
    logic [1:0] in_kind;
    logic       load_full;
    logic       used_zero;
    logic       kind_set;
    logic       kind_get;
    logic       slot_empty;
    logic       slot_tomb;
    logic       slot_match;
    logic       probe_last;
    logic       tomb_valid;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/ohtab_datapath.sv */
// Datapath: request latch, hash and modulo unit, probe registers, slot memory.
// Depends on ohtab_pkg; driven by ohtab_ctrl commands.
`default_nettype none
module ohtab_datapath #(
  parameter int SLOTS = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ohtab_pkg::req_t  req_i,
  input  wire ohtab_pkg::cmd_t  cmd_i,
  output ohtab_pkg::sts_t       sts_o,
  output ohtab_pkg::rsp_t       rsp_o,
  output logic                  done_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam int LW = IW + 4;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);
  localparam logic [LW-1:0] LOAD_LIM = LW'(3 * SLOTS);
  localparam logic [31:0]   RECIP    = 32'(64'd4294967296 / 64'(SLOTS));
  localparam logic [32:0]   SLOTS_W  = 33'(SLOTS);

  function automatic logic [63:0] norm(input logic [1:0] t, input logic [63:0] b);
    if (t == ohtab_pkg::T_BOOL) return {63'd0, |b};
    if (t == ohtab_pkg::T_NIL) return 64'd0;
    return b;
  endfunction

  function automatic logic is_nan(input logic [63:0] b);
    return b[62:0] > 63'h7FF0000000000000;
  endfunction

  function automatic logic keys_eq(input logic [1:0] ta, input logic [63:0] a,
                                   input logic [1:0] tb, input logic [63:0] b);
    if (ta != tb) return 1'b0;
    if (ta == ohtab_pkg::T_NUM) begin
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if ((a[62:0] | b[62:0]) == 63'd0) return 1'b1;
    end
    return a == b;
  endfunction

  ohtab_pkg::slot_t mem_q [SLOTS];
  ohtab_pkg::slot_t rd_q, wr_data;
  ohtab_pkg::req_t  key_q, ld_req;
  ohtab_pkg::rsp_t  rsp_q;
  logic             done_q;
  logic [31:0]      h_q, hash;
  logic [63:0]      prod_q;
  logic             ph_q;
  logic [32:0]      r_est, r_fix;
  logic [IW-1:0]    idx_q, tomb_q, clr_q, wr_addr, idx_inc;
  logic [CW-1:0]    cnt_q, used_q;
  logic             tomb_v_q;
  logic [63:0]      in_kbits;
  logic [LW-1:0]    load_need;

  assign in_kbits = norm(req_i.key_type, req_i.key_bits);

  always_comb begin
    ld_req            = req_i;
    ld_req.key_bits   = in_kbits;
    ld_req.value_bits = norm(req_i.value_type, req_i.value_bits);
  end

  always_comb begin
    unique case (req_i.key_type)
      ohtab_pkg::T_BOOL: hash = (|req_i.key_bits) ? 32'd1 : 32'd2;
      ohtab_pkg::T_NIL:  hash = 32'd3;
      ohtab_pkg::T_NUM:  hash = in_kbits[31:0] ^ in_kbits[63:32];
      default:           hash = req_i.key_is_string ? req_i.key_string_hash
                                                    : in_kbits[31:0];
    endcase
  end

  // quotient estimate is exact or one low: at most one correcting subtract
  assign r_est   = {1'b0, h_q} - 33'(prod_q[63:32]) * SLOTS_W;
  assign r_fix   = (r_est >= SLOTS_W) ? r_est - SLOTS_W : r_est;
  assign idx_inc = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  assign load_need = ({3'd0, used_q} + LW'(1)) << 2;

  always_comb begin
    unique case (cmd_i.wr_sel)
      ohtab_pkg::WR_SET:  wr_data = '{key_q.key_type, key_q.key_bits,
                                      key_q.value_type, key_q.value_bits};
      ohtab_pkg::WR_TOMB: wr_data = '{ohtab_pkg::T_NIL, 64'd0,
                                      ohtab_pkg::T_BOOL, 64'd1};
      default:            wr_data = '{ohtab_pkg::T_NIL, 64'd0,
                                      ohtab_pkg::T_NIL, 64'd0};
    endcase
    if (cmd_i.wr_sel == ohtab_pkg::WR_CLR) wr_addr = clr_q;
    else if (cmd_i.wr_at_idx || !tomb_v_q) wr_addr = idx_q;
    else wr_addr = tomb_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd) rd_q <= mem_q[idx_q];
    if (cmd_i.ld) begin
      key_q <= ld_req;
      h_q   <= hash;
    end
    if (cmd_i.mod && !ph_q) prod_q <= 64'(h_q) * 64'(RECIP);
    if (cmd_i.step && rd_q.key_type == ohtab_pkg::T_NIL && !tomb_v_q) tomb_q <= idx_q;
    if (cmd_i.res) begin
      rsp_q.status     <= cmd_i.res_sts;
      rsp_q.found_type <= cmd_i.res_found ? rd_q.value_type : 2'd0;
      rsp_q.found_bits <= cmd_i.res_found ? rd_q.value_bits : 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      ph_q     <= 1'b0;
      idx_q    <= '0;
      cnt_q    <= '0;
      tomb_v_q <= 1'b0;
      used_q   <= '0;
      clr_q    <= '0;
    end else begin
      done_q <= cmd_i.res;
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.ld) begin
        ph_q     <= 1'b0;
        cnt_q    <= '0;
        tomb_v_q <= 1'b0;
      end
      if (cmd_i.mod) begin
        ph_q <= !ph_q;
        if (ph_q) idx_q <= r_fix[IW-1:0];
      end
      if (cmd_i.step) begin
        idx_q <= idx_inc;
        cnt_q <= cnt_q + 1'b1;
        if (rd_q.key_type == ohtab_pkg::T_NIL) tomb_v_q <= 1'b1;
      end
      if (cmd_i.used_inc) used_q <= used_q + 1'b1;
    end
  end

  always_comb begin
    sts_o.clr_last   = clr_q == LAST_IDX;
    sts_o.mod_last   = ph_q;
    sts_o.in_nil     = req_i.key_type == ohtab_pkg::T_NIL;
    sts_o.in_kind    = req_i.kind;
    sts_o.load_full  = load_need > LOAD_LIM;
    sts_o.used_zero  = used_q == '0;
    sts_o.kind_set   = key_q.kind == ohtab_pkg::KIND_SET;
    sts_o.kind_get   = key_q.kind == ohtab_pkg::KIND_GET;
    sts_o.slot_empty = rd_q.key_type == ohtab_pkg::T_NIL && rd_q.value_type == ohtab_pkg::T_NIL;
    sts_o.slot_tomb  = rd_q.key_type == ohtab_pkg::T_NIL && rd_q.value_type != ohtab_pkg::T_NIL;
    sts_o.slot_match = rd_q.key_type != ohtab_pkg::T_NIL &&
                       keys_eq(rd_q.key_type, rd_q.key_bits, key_q.key_type, key_q.key_bits);
    sts_o.probe_last = cnt_q == CW'(SLOTS - 1);
    sts_o.tomb_valid = tomb_v_q;
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({3'd0, used_q} << 2) <= LOAD_LIM)
    else $error("used slot count beyond load limit");
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < SLOTS_C)
    else $error("probe count past one full pass");
  a_used_inc_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.used_inc |-> cmd_i.wr && !tomb_v_q && !sts_o.slot_match)
    else $error("used count raised on a hit or reused tombstone");

endmodule
`default_nettype wire

/* rtl/core/ohtab_ctrl.sv */
// Controller state machine for the hash table core.
// Depends on ohtab_pkg; issues commands to ohtab_datapath.
`default_nettype none
module ohtab_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire ohtab_pkg::sts_t  sts_i,
  output ohtab_pkg::cmd_t       cmd_o,
  output logic                  busy_o
);

  ohtab_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ohtab_pkg::S_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = state_q != ohtab_pkg::S_IDLE;
    unique case (state_q)
      ohtab_pkg::S_CLEAR: begin
        cmd_o.clr    = 1'b1;
        cmd_o.wr     = 1'b1;
        cmd_o.wr_sel = ohtab_pkg::WR_CLR;
        if (sts_i.clr_last) state_d = ohtab_pkg::S_IDLE;
      end
      ohtab_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.ld = 1'b1;
          if (sts_i.in_nil) begin
            cmd_o.res     = 1'b1;
            cmd_o.res_sts = ohtab_pkg::ST_NIL;
          end else if (sts_i.in_kind == ohtab_pkg::KIND_SET) begin
            if (sts_i.load_full) begin
              cmd_o.res     = 1'b1;
              cmd_o.res_sts = ohtab_pkg::ST_FULL;
            end else state_d = ohtab_pkg::S_HASH;
          end else if (sts_i.in_kind == ohtab_pkg::KIND_GET ||
                       sts_i.in_kind == ohtab_pkg::KIND_DEL) begin
            if (sts_i.used_zero) begin
              cmd_o.res     = 1'b1;
              cmd_o.res_sts = ohtab_pkg::ST_MISS;
            end else state_d = ohtab_pkg::S_HASH;
          end else begin
            cmd_o.res     = 1'b1;
            cmd_o.res_sts = ohtab_pkg::ST_MISS;
          end
        end
      end
      ohtab_pkg::S_HASH: begin
        cmd_o.mod = 1'b1;
        if (sts_i.mod_last) state_d = ohtab_pkg::S_READ;
      end
      ohtab_pkg::S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ohtab_pkg::S_CHECK;
      end
      ohtab_pkg::S_CHECK: begin
        state_d = ohtab_pkg::S_IDLE;
        cmd_o.res = 1'b1;
        if (sts_i.slot_match) begin
          if (sts_i.kind_set) begin
            cmd_o.wr        = 1'b1;
            cmd_o.wr_sel    = ohtab_pkg::WR_SET;
            cmd_o.wr_at_idx = 1'b1;
            cmd_o.res_sts   = ohtab_pkg::ST_MISS;
          end else if (sts_i.kind_get) begin
            cmd_o.res_sts   = ohtab_pkg::ST_OK;
            cmd_o.res_found = 1'b1;
          end else begin
            cmd_o.wr        = 1'b1;
            cmd_o.wr_sel    = ohtab_pkg::WR_TOMB;
            cmd_o.wr_at_idx = 1'b1;
            cmd_o.res_sts   = ohtab_pkg::ST_OK;
          end
        end else if (sts_i.slot_empty) begin
          if (sts_i.kind_set) begin
            cmd_o.wr       = 1'b1;
            cmd_o.wr_sel   = ohtab_pkg::WR_SET;
            cmd_o.used_inc = !sts_i.tomb_valid;
            cmd_o.res_sts  = ohtab_pkg::ST_OK;
          end else cmd_o.res_sts = ohtab_pkg::ST_MISS;
        end else if (sts_i.probe_last) begin
          // full pass done: reuse a tombstone if one was seen
          if (sts_i.kind_set && (sts_i.tomb_valid || sts_i.slot_tomb)) begin
            cmd_o.wr      = 1'b1;
            cmd_o.wr_sel  = ohtab_pkg::WR_SET;
            cmd_o.res_sts = ohtab_pkg::ST_OK;
          end else if (sts_i.kind_set) cmd_o.res_sts = ohtab_pkg::ST_FULL;
          else cmd_o.res_sts = ohtab_pkg::ST_MISS;
        end else begin
          cmd_o.res  = 1'b0;
          cmd_o.step = 1'b1;
          state_d    = ohtab_pkg::S_READ;
        end
      end
      default: state_d = ohtab_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/open_addressing_hash_table_core.sv */
// Top level of the open addressing hash table core.
// Depends on ohtab_pkg, ohtab_ctrl and ohtab_datapath.
//
// channel   signals                 handshake
// request   start, req_i            taken when start && !busy
// result    done_o, rsp_o           valid one cycle, no backpressure
//
// Nil keys, unused kinds, a full table or an empty table are answered from idle.
// Otherwise: an accept step, then hash mod SLOTS (reciprocal multiply, then the
// remainder with one correcting subtract), then per probed slot a registered
// memory read and a compare. The result appears the cycle after the last step.
// After reset the slot memory is cleared, one slot a cycle, while busy is high.
// The result cannot be stalled.
`default_nettype none
module open_addressing_hash_table_core #(
  parameter int SLOTS = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire ohtab_pkg::req_t req_i,
  output logic                 done_o,
  output ohtab_pkg::rsp_t      rsp_o
);

  ohtab_pkg::cmd_t cmd;
  ohtab_pkg::sts_t sts;

  ohtab_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ohtab_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule
`default_nettype wire
